### design/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg: shared definitions for the palette LED fade frame buffer
// Request modes, register indexes, the serpentine slot map and the fade step.
// ----------------------------------------------------------------------------
package plf_pkg;

    localparam int PIXEL_COUNT_DEF = 114;
    localparam int ROM_LENGTH      = 114;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_LOAD_NOW = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_READ     = 2'd3
    } plf_mode_t;

    localparam logic [CFG_AW-1:0] REG_BRIGHTNESS    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PALETTE_ZERO  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PALETTE_ONE   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PALETTE_TWO   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PALETTE_THREE = 3'd4;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;

    // four 24-bit colors, red in the top byte
    typedef logic [3:0][23:0] plf_palette_t;

    // memory port controls from the sequencer to the stores
    typedef struct packed {
        logic tgt_we;
        logic cur_we;
        logic rd_en;
    } plf_mem_ctl_t;

    // readout controls from the sequencer to the output stage
    typedef struct packed {
        logic load;
        logic zero;
    } plf_rd_ctl_t;

    // logical pixel to physical slot, rows wired in a serpentine
    localparam logic [6:0] SLOT_ROM [ROM_LENGTH] = '{
        7'd10,  7'd9,   7'd8,   7'd7,   7'd6,   7'd5,   7'd4,   7'd3,   7'd2,   7'd1,   7'd0,
        7'd11,  7'd12,  7'd13,  7'd14,  7'd15,  7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,
        7'd32,  7'd31,  7'd30,  7'd29,  7'd28,  7'd27,  7'd26,  7'd25,  7'd24,  7'd23,  7'd22,
        7'd33,  7'd34,  7'd35,  7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
        7'd54,  7'd53,  7'd52,  7'd51,  7'd50,  7'd49,  7'd48,  7'd47,  7'd46,  7'd45,  7'd44,
        7'd55,  7'd56,  7'd57,  7'd58,  7'd59,  7'd60,  7'd61,  7'd62,  7'd63,  7'd64,  7'd65,
        7'd76,  7'd75,  7'd74,  7'd73,  7'd72,  7'd71,  7'd70,  7'd69,  7'd68,  7'd67,  7'd66,
        7'd77,  7'd78,  7'd79,  7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
        7'd98,  7'd97,  7'd96,  7'd95,  7'd94,  7'd93,  7'd92,  7'd91,  7'd90,  7'd89,  7'd88,
        7'd99,  7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109,
        7'd112, 7'd111, 7'd110, 7'd113
    };

    // move one byte toward its target: coarse when far, single steps when close
    function automatic logic [7:0] fade_byte(input logic [7:0] cur, input logic [7:0] tgt);
        logic signed [8:0] d;
        logic [7:0] step;
        d = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        priority if (d > 9'sd64) begin
            step = 8'd8;
        end else if (d > 9'sd16) begin
            step = 8'd4;
        end else if (d > 9'sd0) begin
            step = 8'd1;
        end else if (d < -9'sd64) begin
            step = 8'hF8;
        end else if (d < -9'sd16) begin
            step = 8'hFC;
        end else if (d < 9'sd0) begin
            step = 8'hFF;
        end else begin
            step = 8'd0;
        end
        return cur + step;
    endfunction

endpackage

### design/plf_store.sv
// ----------------------------------------------------------------------------
// plf_store: target and current color memories
// One 24-bit RGB row per slot, shared write address, registered read data.
// ----------------------------------------------------------------------------
module plf_store
    import plf_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  logic              aclk,
    input  plf_mem_ctl_t      mem_ctl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [23:0]       tgt_wdata,
    input  logic [23:0]       cur_wdata,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [23:0]       tgt_rdata,
    output logic [23:0]       cur_rdata
);

    logic [23:0] tgt_mem [PIXEL_COUNT];
    logic [23:0] cur_mem [PIXEL_COUNT];
    logic [23:0] tgt_rdata_reg;
    logic [23:0] cur_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.tgt_we) begin
            tgt_mem[wr_addr] <= tgt_wdata;
        end
        if (mem_ctl.cur_we) begin
            cur_mem[wr_addr] <= cur_wdata;
        end
    end

    // hold read data until the next read request
    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            tgt_rdata_reg <= tgt_mem[rd_addr];
            cur_rdata_reg <= cur_mem[rd_addr];
        end
    end

    assign tgt_rdata = tgt_rdata_reg;
    assign cur_rdata = cur_rdata_reg;

endmodule

### design/plf_seq.sv
// ----------------------------------------------------------------------------
// plf_seq: request sequencer
// Clears the stores after reset, maps loads to slots, walks the stores on a
// fade tick with read-modify-write, and issues pixel reads.
// ----------------------------------------------------------------------------
module plf_seq
    import plf_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        mode,
    input  logic [6:0]        pixel_number,
    input  logic [1:0]        color_index,
    input  plf_palette_t      palette,
    output plf_mem_ctl_t      mem_ctl,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [23:0]       tgt_wdata,
    output logic [23:0]       cur_wdata,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [23:0]       tgt_rdata,
    input  logic [23:0]       cur_rdata,
    input  logic              out_free,
    output plf_rd_ctl_t       rd_ctl
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_FADE  = 4'b0100,
        ST_READ  = 4'b1000
    } plf_state_t;

    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(PIXEL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_ONE  = ADDR_W'(1);

    plf_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              issue_reg, issue_next;
    logic              wb_reg, wb_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    logic              rd_zero_reg, rd_zero_next;

    logic              accept;
    logic [8:0]        pix_cmp;
    logic [7:0]        pix_wide;
    logic [6:0]        slot;
    logic [7:0]        slot_wide;
    logic              pix_ok;
    logic              slot_ok;
    logic [23:0]       fade_row;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign pix_cmp   = {2'b00, pixel_number};
    assign pix_wide  = {1'b0, pixel_number};
    assign pix_ok    = pix_cmp < 9'(PIXEL_COUNT);
    assign slot      = (pix_cmp < 9'(ROM_LENGTH)) ? SLOT_ROM[pixel_number] : pixel_number;
    assign slot_wide = {1'b0, slot};
    assign slot_ok   = pix_ok && ({2'b00, slot} < 9'(PIXEL_COUNT));

    assign fade_row = {fade_byte(cur_rdata[23:16], tgt_rdata[23:16]),
                       fade_byte(cur_rdata[15:8],  tgt_rdata[15:8]),
                       fade_byte(cur_rdata[7:0],   tgt_rdata[7:0])};

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        issue_next   = issue_reg;
        wb_next      = 1'b0;
        wb_addr_next = wb_addr_reg;
        rd_zero_next = rd_zero_reg;
        mem_ctl      = '0;
        wr_addr      = ptr_reg;
        rd_addr      = ptr_reg;
        tgt_wdata    = '0;
        cur_wdata    = '0;
        rd_ctl       = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_ctl.tgt_we = 1'b1;
                mem_ctl.cur_we = 1'b1;
                ptr_next       = ptr_reg + ROW_ONE;
                if (ptr_reg == LAST_ROW) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                wr_addr   = slot_wide[ADDR_W-1:0];
                rd_addr   = pix_wide[ADDR_W-1:0];
                tgt_wdata = palette[color_index];
                cur_wdata = palette[color_index];
                if (accept) begin
                    unique case (mode)
                        MODE_LOAD, MODE_LOAD_NOW: begin
                            // drop loads that land outside the strip
                            mem_ctl.tgt_we = slot_ok;
                            mem_ctl.cur_we = slot_ok && (mode == MODE_LOAD_NOW);
                        end
                        MODE_TICK: begin
                            ptr_next   = '0;
                            issue_next = 1'b1;
                            state_next = ST_FADE;
                        end
                        MODE_READ: begin
                            mem_ctl.rd_en = pix_ok;
                            rd_zero_next  = !pix_ok;
                            state_next    = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FADE: begin
                // read row n while row n-1 is written back
                if (issue_reg) begin
                    mem_ctl.rd_en = 1'b1;
                    ptr_next      = ptr_reg + ROW_ONE;
                    wb_next       = 1'b1;
                    wb_addr_next  = ptr_reg;
                    if (ptr_reg == LAST_ROW) begin
                        issue_next = 1'b0;
                    end
                end
                if (wb_reg) begin
                    mem_ctl.cur_we = 1'b1;
                    wr_addr        = wb_addr_reg;
                    cur_wdata      = fade_row;
                end
                if (!issue_reg && wb_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                rd_ctl.load = out_free;
                rd_ctl.zero = rd_zero_reg;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                ptr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            issue_reg   <= 1'b0;
            wb_reg      <= 1'b0;
            rd_zero_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            issue_reg   <= issue_next;
            wb_reg      <= wb_next;
            rd_zero_reg <= rd_zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_addr_reg <= wb_addr_next;
    end

endmodule

### design/plf_out.sv
// ----------------------------------------------------------------------------
// plf_out: brightness scaling and result register
// Multiplies each byte of the read row by the brightness, keeps the high byte.
// ----------------------------------------------------------------------------
module plf_out
    import plf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  plf_rd_ctl_t rd_ctl,
    input  logic [23:0] cur_rdata,
    input  logic [7:0]  brightness,
    output logic        out_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    logic        m_tvalid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [15:0] prod_red, prod_green, prod_blue;

    assign prod_red   = 16'(cur_rdata[23:16]) * 16'(brightness);
    assign prod_green = 16'(cur_rdata[15:8])  * 16'(brightness);
    assign prod_blue  = 16'(cur_rdata[7:0])   * 16'(brightness);

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rd_ctl.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // out-of-range pixels read as black
    always_ff @(posedge aclk) begin
        if (rd_ctl.load) begin
            red_reg   <= rd_ctl.zero ? 8'd0 : prod_red[15:8];
            green_reg <= rd_ctl.zero ? 8'd0 : prod_green[15:8];
            blue_reg  <= rd_ctl.zero ? 8'd0 : prod_blue[15:8];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

endmodule

### design/palette_led_fade_frame_buffer_top.sv
// ----------------------------------------------------------------------------
// palette_led_fade_frame_buffer_top: LED frame buffer with palette and fade
//
// Requests arrive on the s_ stream: mode selects load target, load target and
// current, fade tick or read pixel. Only reads give a result, on the m_ stream
// as one brightness-scaled RGB triple. Registers (brightness, four palette
// colors) are written through cfg_we/cfg_addr/cfg_wdata; the user is to write
// them while the block idles, which the block itself does not enforce.
// Loads leave s_tready high: the next request is accepted in the following cycle.
// A read registers the row in the store read register, then, once the output
// register is free, loads its brightness-scaled result into the output register.
// A fade tick keeps s_tready low while the sequencer reads one row of both
// memories per cycle and writes back the faded current row in the following cycle.
// After reset the block clears both memories, one row per cycle, with s_tready
// low; registers can be written meanwhile. When the receiver stalls, the result
// stays in the output register and a following read waits for it; loads and
// ticks continue meanwhile.
module palette_led_fade_frame_buffer_top
    import plf_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // mode[1:0], pixel_number[8:2], color_index[10:9]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    logic [7:0]        brightness_reg;
    plf_palette_t      palette_reg;

    plf_mem_ctl_t      mem_ctl;
    plf_rd_ctl_t       rd_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [23:0]       tgt_wdata, cur_wdata;
    logic [23:0]       tgt_rdata, cur_rdata;
    logic              out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHTNESS_RESET;
            palette_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BRIGHTNESS:    brightness_reg <= cfg_wdata[7:0];
                REG_PALETTE_ZERO:  palette_reg[0] <= cfg_wdata;
                REG_PALETTE_ONE:   palette_reg[1] <= cfg_wdata;
                REG_PALETTE_TWO:   palette_reg[2] <= cfg_wdata;
                REG_PALETTE_THREE: palette_reg[3] <= cfg_wdata;
                default: begin
                    brightness_reg <= brightness_reg;
                end
            endcase
        end
    end

    plf_seq #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .mode         (s_tdata[1:0]),
        .pixel_number (s_tdata[8:2]),
        .color_index  (s_tdata[10:9]),
        .palette      (palette_reg),
        .mem_ctl      (mem_ctl),
        .wr_addr      (wr_addr),
        .tgt_wdata    (tgt_wdata),
        .cur_wdata    (cur_wdata),
        .rd_addr      (rd_addr),
        .tgt_rdata    (tgt_rdata),
        .cur_rdata    (cur_rdata),
        .out_free     (out_free),
        .rd_ctl       (rd_ctl)
    );

    plf_store #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_store (
        .aclk      (aclk),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .tgt_wdata (tgt_wdata),
        .cur_wdata (cur_wdata),
        .rd_addr   (rd_addr),
        .tgt_rdata (tgt_rdata),
        .cur_rdata (cur_rdata)
    );

    plf_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_ctl     (rd_ctl),
        .cur_rdata  (cur_rdata),
        .brightness (brightness_reg),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### design/plf_checker.sv
// ----------------------------------------------------------------------------
// plf_checker: port-level checks for the frame buffer
// Watches reset, request sequencing and the result handshake.
// ----------------------------------------------------------------------------
module plf_checker
    import plf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // clear pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("request accepted during clear pass");

    // reads and ticks hold s_tready low after they are accepted
    a_busy_after_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[1:0] == MODE_READ || s_tdata[1:0] == MODE_TICK))
        |=> !s_tready)
        else $error("request accepted while busy");

    // a read into an empty output shows its result after the store read register and the output register
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[1:0] == MODE_READ && !m_tvalid)
        |-> ##2 m_tvalid)
        else $error("read result missing");

    // hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind palette_led_fade_frame_buffer_top plf_checker u_plf_checker (.*);

### bench/palette_led_fade_frame_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// palette_led_fade_frame_buffer_top_tb: self-checking bench for the LED buffer
// Drives load, immediate load, fade tick and read requests over the s_ stream.
// A behavioral copy of the target and current stores predicts every readout.
// Each m_ result is checked against the oldest prediction, field by field.
// Sender and receiver idle at random; the palette and brightness change
// between blocks of requests while the block is quiet.
// ----------------------------------------------------------------------------
module palette_led_fade_frame_buffer_top_tb;
    import plf_pkg::*;

    localparam int PIXELS        = PIXEL_COUNT_DEF;
    localparam int STORE_BYTES   = 3 * PIXELS;
    localparam int SETTLE_CYCLES = 160;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;  // mode[1:0], pixel_number[8:2], color_index[10:9]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;        // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic              cfg_we   = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    // behavioral frame state
    logic [7:0]  tgt_bytes [STORE_BYTES];
    logic [7:0]  cur_bytes [STORE_BYTES];
    logic [7:0]  level;
    logic [23:0] colors [4];
    rgb_t        expected_rgb_q [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int err_count   = 0;
    int cycle_count = 0;
    bit busy        = 1'b0;

    palette_led_fade_frame_buffer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------- prediction ----------------

    // logical pixel to physical slot: rows of eleven, every other row reversed
    function automatic int serpentine_slot(input int pix);
        int row;
        int col;
        row = pix / 11;
        col = pix % 11;
        if (pix >= 110) begin
            return (pix == 113) ? 113 : 222 - pix;
        end
        if (row % 2 == 0) begin
            return row * 11 + 10 - col;
        end
        return row * 11 + col;
    endfunction

    function automatic logic [7:0] fade_toward(input logic [7:0] cur, input logic [7:0] tgt);
        int gap;
        int step;
        gap = int'(tgt) - int'(cur);
        if (gap > 64) step = 8;
        else if (gap > 16) step = 4;
        else if (gap > 0) step = 1;
        else if (gap < -64) step = -8;
        else if (gap < -16) step = -4;
        else if (gap < 0) step = -1;
        else step = 0;
        return 8'(int'(cur) + step);
    endfunction

    function automatic logic [7:0] dimmed(input logic [7:0] v);
        logic [15:0] prod;
        prod = 16'(v) * 16'(level);
        return prod[15:8];
    endfunction

    task automatic frame_apply(input plf_mode_t mode, input logic [6:0] pix,
                               input logic [1:0] ci);
        int   base;
        rgb_t want;
        case (mode)
            MODE_LOAD, MODE_LOAD_NOW: begin
                if (pix < PIXELS) begin
                    base = 3 * serpentine_slot(pix);
                    tgt_bytes[base]     = colors[ci][23:16];
                    tgt_bytes[base + 1] = colors[ci][15:8];
                    tgt_bytes[base + 2] = colors[ci][7:0];
                    if (mode == MODE_LOAD_NOW) begin
                        for (int k = 0; k < 3; k++) cur_bytes[base + k] = tgt_bytes[base + k];
                    end
                end
            end
            MODE_TICK: begin
                for (int k = 0; k < STORE_BYTES; k++) begin
                    cur_bytes[k] = fade_toward(cur_bytes[k], tgt_bytes[k]);
                end
            end
            default: begin
                want = '0;
                if (pix < PIXELS) begin
                    want.red   = dimmed(cur_bytes[3 * pix]);
                    want.green = dimmed(cur_bytes[3 * pix + 1]);
                    want.blue  = dimmed(cur_bytes[3 * pix + 2]);
                end
                expected_rgb_q = {expected_rgb_q, want};
            end
        endcase
    endtask

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        rgb_t want;
        rgb_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.red   = m_tdata[7:0];
            got.green = m_tdata[15:8];
            got.blue  = m_tdata[23:16];
            if (expected_rgb_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected readout r=%0d g=%0d b=%0d", got.red, got.green,
                             got.blue);
            end else begin
                want = expected_rgb_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue, got.red, got.green,
                                 got.blue);
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_request(input plf_mode_t mode, input logic [6:0] pix,
                                input logic [1:0] ci);
        int   gap;
        logic taken;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, ci, pix, mode};
        do begin
            @(posedge aclk);
            taken = s_tready;
        end while (!taken);
        frame_apply(mode, pix, ci);
        busy = 1'b1;
        @(negedge aclk);
    endtask

    // drain readouts, then give a fade tick time to finish
    task automatic settle();
        s_tvalid = 1'b0;
        if (busy) begin
            while (expected_rgb_q.size() != 0) @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
            busy = 1'b0;
        end
    endtask

    task automatic write_reg(input int idx, input logic [23:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_addr  = CFG_AW'(idx);
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_BRIGHTNESS) level = value[7:0];
        else if (idx >= REG_PALETTE_ZERO && idx <= REG_PALETTE_THREE)
            colors[idx - REG_PALETTE_ZERO] = value;
    endtask

    function automatic logic [23:0] pick_color();
        case ($urandom_range(3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [6:0] pick_pixel();
        if ($urandom_range(99) < 8) return 7'($urandom_range(127, PIXELS));
        return 7'($urandom_range(PIXELS - 1));
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_state();
        send_request(MODE_READ, 7'd0, 2'd0);
        send_request(MODE_READ, 7'(PIXELS - 1), 2'd3);
    endtask

    task automatic test_directed();
        write_reg(REG_PALETTE_ZERO, 24'h000000);
        write_reg(REG_PALETTE_ONE, 24'hFFFFFF);
        write_reg(REG_PALETTE_TWO, 24'hA53C5A);
        write_reg(REG_PALETTE_THREE, 24'h5AC3A5);
        // immediate loads at both ends of the pixel range
        send_request(MODE_LOAD_NOW, 7'd0, 2'd1);
        send_request(MODE_READ, 7'd10, 2'd0);
        send_request(MODE_LOAD_NOW, 7'd113, 2'd2);
        send_request(MODE_READ, 7'd113, 2'd0);
        send_request(MODE_LOAD_NOW, 7'd110, 2'd3);
        send_request(MODE_READ, 7'd112, 2'd0);
        // loads past the last pixel leave everything alone
        send_request(MODE_LOAD, 7'd127, 2'd3);
        send_request(MODE_LOAD_NOW, 7'(PIXELS), 2'd1);
        send_request(MODE_READ, 7'(PIXELS), 2'd0);
        send_request(MODE_READ, 7'd127, 2'd3);
        // target only, then fade tick with junk in the ignored fields
        send_request(MODE_LOAD, 7'd11, 2'd1);
        send_request(MODE_READ, 7'd11, 2'd0);
        send_request(MODE_TICK, 7'd127, 2'd3);
        send_request(MODE_READ, 7'd11, 2'd0);
        send_request(MODE_LOAD, 7'd0, 2'd0);
        send_request(MODE_TICK, 7'd0, 2'd0);
        send_request(MODE_READ, 7'd10, 2'd0);
        // writes to unused indexes must not disturb anything
        for (int a = REG_PALETTE_THREE + 1; a < 2 ** CFG_AW; a++) write_reg(a, 24'hFFFFFF);
        send_request(MODE_READ, 7'd113, 2'd0);
        write_reg(REG_BRIGHTNESS, 24'd0);
        send_request(MODE_READ, 7'd113, 2'd0);
        write_reg(REG_BRIGHTNESS, 24'd128);
        send_request(MODE_READ, 7'd112, 2'd0);
        write_reg(REG_BRIGHTNESS, 24'd255);
    endtask

    task automatic random_block(input int count);
        int        r;
        plf_mode_t mode;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 30) mode = MODE_LOAD;
            else if (r < 45) mode = MODE_LOAD_NOW;
            else if (r < 58) mode = MODE_TICK;
            else mode = MODE_READ;
            send_request(mode, pick_pixel(), 2'($urandom_range(3)));
        end
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        logic [7:0] lvl;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int b = 0; b < 5; b++) begin
            case ($urandom_range(3))
                0: lvl = 8'd255;
                1: lvl = 8'd1;
                default: lvl = 8'($urandom);
            endcase
            write_reg(REG_BRIGHTNESS, {16'd0, lvl});
            for (int p = REG_PALETTE_ZERO; p <= REG_PALETTE_THREE; p++)
                write_reg(p, pick_color());
            random_block(50);
        end
    endtask

    initial begin
        for (int k = 0; k < STORE_BYTES; k++) begin
            tgt_bytes[k] = '0;
            cur_bytes[k] = '0;
        end
        level = BRIGHTNESS_RESET;
        for (int c = 0; c < 4; c++) colors[c] = '0;

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        tx_idle_pct = 16;
        rx_idle_pct = 71;
        test_reset_state();
        test_directed();
        test_random_phase(16, 71);
        test_random_phase(71, 16);
        test_random_phase(0, 0);

        settle();
        if (err_count == 0 && expected_rgb_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
